// File: hw/rtl/double_ended_queue_top_defines.svh
// Assertion macros for the files that assert; only the top-level file uses them.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define DEQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_RDWAIT,
    EX_SHIFT_RD,
    EX_SHIFT_WR,
    EX_FINAL,
    EX_OUT
  } ex_state_t;

  // Request as handed from the front end to the execution unit.
  typedef struct packed {
    op_t              op;
    logic [10:0]      position;
    logic [WIDTH-1:0] word;
  } req_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic [10:0] fill_count;
    logic        is_empty;
    status_t     status;
  } rsp_t;

endpackage

// File: hw/rtl/deq_fifo.sv
module deq_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output deq_pkg::req_t out_data
);

  localparam int unsigned PW = $clog2(deq_pkg::QDEPTH);

  deq_pkg::req_t mem [deq_pkg::QDEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count < (PW+1)'(deq_pkg::QDEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// File: hw/rtl/deq_exec.sv
module deq_exec (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  deq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output deq_pkg::rsp_t rsp
);

  localparam int unsigned AW = deq_pkg::AW;
  localparam int unsigned CW = deq_pkg::CW;

  logic [deq_pkg::WIDTH-1:0] ram [deq_pkg::DEPTH];
  logic [deq_pkg::WIDTH-1:0] rd_data;
  logic [AW-1:0]             rd_addr;
  logic                      rd_en;
  logic [AW-1:0]             wr_addr;
  logic [deq_pkg::WIDTH-1:0] wr_data;
  logic                      wr_en;

  deq_pkg::ex_state_t state;
  deq_pkg::ex_state_t state_next;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  deq_pkg::req_t cur;
  logic [CW-1:0] idx;
  logic [CW-1:0] stop;
  logic          dir_up;
  logic [deq_pkg::WIDTH-1:0] hold;
  deq_pkg::rsp_t out_reg;
  logic          out_v;

  // Combinational decode of the incoming request.
  logic          take;
  logic          fast;
  deq_pkg::status_t st;
  logic [CW-1:0] pos_c;

  assign pos_c = req.position;
  assign take  = req_valid && req_ready;

  always_comb begin
    st   = deq_pkg::ST_OK;
    fast = 1'b1;
    case (req.op)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (cnt >= CW'(deq_pkg::DEPTH)) st = deq_pkg::ST_FULL;
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT: begin
        if (cnt == '0) st = deq_pkg::ST_EMPTY;
      end
      deq_pkg::OP_READ: begin
        if (pos_c >= cnt) st = deq_pkg::ST_RANGE;
        else fast = 1'b0;
      end
      deq_pkg::OP_INSERT: begin
        if (pos_c > cnt) st = deq_pkg::ST_RANGE;
        else if (cnt >= CW'(deq_pkg::DEPTH)) st = deq_pkg::ST_FULL;
        else fast = 1'b0;
      end
      deq_pkg::OP_ERASE: begin
        if (cnt == '0) st = deq_pkg::ST_EMPTY;
        else if (pos_c >= cnt) st = deq_pkg::ST_RANGE;
        else fast = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign req_ready = (state == deq_pkg::EX_IDLE) && !(out_v && !rsp_ready);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      deq_pkg::EX_IDLE: begin
        if (take && !fast) begin
          if (req.op == deq_pkg::OP_READ) state_next = deq_pkg::EX_RDWAIT;
          else state_next = deq_pkg::EX_SHIFT_RD;
        end
      end
      deq_pkg::EX_RDWAIT:   state_next = deq_pkg::EX_OUT;
      deq_pkg::EX_SHIFT_RD: begin
        if (idx == stop) state_next = deq_pkg::EX_FINAL;
        else state_next = deq_pkg::EX_SHIFT_WR;
      end
      deq_pkg::EX_SHIFT_WR: state_next = deq_pkg::EX_SHIFT_RD;
      deq_pkg::EX_FINAL:    state_next = deq_pkg::EX_OUT;
      deq_pkg::EX_OUT: begin
        if (!out_v || rsp_ready) state_next = deq_pkg::EX_IDLE;
      end
      default: state_next = deq_pkg::EX_IDLE;
    endcase
  end

  // Memory port control. A shift step reads logical idx+-1 then writes idx.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head + AW'(pos_c);
    wr_en   = 1'b0;
    wr_addr = head + AW'(idx);
    wr_data = hold;
    head_next = head;
    cnt_next  = cnt;
    case (state)
      deq_pkg::EX_IDLE: begin
        if (take) begin
          case (req.op)
            deq_pkg::OP_PUSH_BACK: begin
              if (st == deq_pkg::ST_OK) begin
                wr_en = 1'b1;
                wr_addr = head + AW'(cnt);
                wr_data = req.word;
                cnt_next = cnt + 1'b1;
              end
            end
            deq_pkg::OP_PUSH_FRONT: begin
              if (st == deq_pkg::ST_OK) begin
                wr_en = 1'b1;
                wr_addr = head - 1'b1;
                wr_data = req.word;
                head_next = head - 1'b1;
                cnt_next = cnt + 1'b1;
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (st == deq_pkg::ST_OK) cnt_next = cnt - 1'b1;
            end
            deq_pkg::OP_POP_FRONT: begin
              if (st == deq_pkg::ST_OK) begin
                head_next = head + 1'b1;
                cnt_next = cnt - 1'b1;
              end
            end
            deq_pkg::OP_READ: rd_en = (st == deq_pkg::ST_OK);
            deq_pkg::OP_INSERT: begin
              // Inserting on the front side opens a slot below the head.
              if (st == deq_pkg::ST_OK &&
                  (pos_c == '0 || (pos_c != cnt && pos_c < (cnt >> 1)))) begin
                head_next = head - 1'b1;
              end
            end
            deq_pkg::OP_CLEAR: cnt_next = '0;
            default: begin
            end
          endcase
        end
      end
      deq_pkg::EX_SHIFT_RD: begin
        rd_en = (idx != stop);
        rd_addr = dir_up ? head + AW'(idx) + 1'b1 : head + AW'(idx) - 1'b1;
      end
      deq_pkg::EX_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_data = rd_data;
      end
      deq_pkg::EX_FINAL: begin
        if (cur.op == deq_pkg::OP_INSERT) begin
          wr_en = 1'b1;
          wr_data = cur.word;
          cnt_next = cnt + 1'b1;
        end else begin
          cnt_next = cnt - 1'b1;
          if (!dir_up) head_next = head + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) ram[wr_addr] <= wr_data;
    if (rd_en) rd_data <= ram[rd_addr];
  end

  // Set up the shift: for insert toward the front the head moves down first,
  // so the cells 0..pos-1 copy from idx+1 side. Erase toward the front moves
  // down from idx to 1 copying from the lower neighbor and then bumps head.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::EX_IDLE;
      head  <= '0;
      cnt   <= '0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      out_v <= (out_v && !rsp_ready) ||
               (state == deq_pkg::EX_IDLE && take && fast) ||
               (state == deq_pkg::EX_OUT && (!out_v || rsp_ready));
      if (state == deq_pkg::EX_IDLE && take) begin
        if (req.op == deq_pkg::OP_INSERT && st == deq_pkg::ST_OK) begin
          if (pos_c != '0 && pos_c != cnt && pos_c < (cnt >> 1)) begin
            dir_up <= 1'b1; idx <= '0; stop <= pos_c;
          end else if (pos_c == '0) begin
            dir_up <= 1'b1; idx <= '0; stop <= '0;
          end else begin
            dir_up <= 1'b0; idx <= cnt; stop <= pos_c;
          end
        end else if (req.op == deq_pkg::OP_ERASE && st == deq_pkg::ST_OK) begin
          if (pos_c < (cnt >> 1)) begin
            dir_up <= 1'b0; idx <= pos_c; stop <= '0;
          end else begin
            dir_up <= 1'b1; idx <= pos_c; stop <= cnt - 1'b1;
          end
        end
      end
      if (state == deq_pkg::EX_SHIFT_WR) begin
        idx <= dir_up ? idx + 1'b1 : idx - 1'b1;
      end
    end
  end

  // In the front-insert case head moved before the shift; the final write
  // goes to logical idx which equals stop in both directions.
  always_ff @(posedge clk) begin
    if (state == deq_pkg::EX_IDLE && take) begin
      cur <= req;
      out_reg.word_out   <= '0;
      out_reg.status     <= st;
      out_reg.fill_count <= cnt_next;
      out_reg.is_empty   <= (cnt_next == '0);
    end
    if (state == deq_pkg::EX_RDWAIT) begin
      out_reg.word_out <= 32'(rd_data);
    end
    if (state == deq_pkg::EX_FINAL) begin
      out_reg.fill_count <= cnt_next;
      out_reg.is_empty   <= (cnt_next == '0);
    end
  end

  assign hold      = rd_data;
  assign rsp_valid = out_v;
  assign rsp       = out_reg;

endmodule

// File: hw/rtl/double_ended_queue_top.sv
// Double-ended queue of 32-bit words with room for 1024 entries.
// Requests arrive on the s_axis channel: each transaction carries an
// operation (push or pop at either end, read, insert, erase, clear), a
// logical position counted from the front, and a word to store.
// Every request yields exactly one response transaction on m_axis with the
// read word, the fill count after the request, an empty flag and a status.
// A front end queues requests in a two-entry buffer; the execution unit
// drains it once idle and owns the word memory, head, count.
// Pushes, pops, clear and rejected requests finish in the idle state of the
// execution unit, so a new request is accepted every cycle while the
// receiver takes the responses. A read passes through a wait state because
// the memory read data is registered. Insert and erase move words one at a
// time, each by a shift read state and a shift write state; the number of
// words moved is at most about half the count.
// The response sits in an output register; a stalled receiver holds it and
// the execution unit waits, while the request buffer still fills.
// Reset empties the queue and the buffers; memory contents are left as is.
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: mode[2:0], position[13:3], word_in[45:14].
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: word_out[31:0], fill_count[42:32], is_empty[43],
  // status[45:44].
  output logic [47:0] m_axis_tdata
);

  deq_pkg::req_t in_req;
  deq_pkg::req_t q_req;
  deq_pkg::rsp_t rsp;
  logic          q_valid;
  logic          q_ready;

  assign in_req.op       = deq_pkg::op_t'(s_axis_tdata[2:0]);
  assign in_req.position = s_axis_tdata[13:3];
  assign in_req.word     = s_axis_tdata[45:14];

  deq_fifo u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(in_req),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
  );

  deq_exec u_exec (
    .clk(clk), .rst(rst),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
  );

  assign m_axis_tdata = {2'b00, rsp.status, rsp.is_empty, rsp.fill_count, rsp.word_out};

  `DEQ_ASSERT_IMPL(a_count_range, 1'b1, rsp.fill_count <= 11'd1024 || !m_axis_tvalid,
    "fill count beyond capacity")
  `DEQ_ASSERT_IMPL(a_empty_flag, m_axis_tvalid,
    rsp.is_empty == (rsp.fill_count == 11'd0), "empty flag disagrees with count")
  `DEQ_ASSERT_NEXT(a_rsp_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled response changed")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

// Request and response stimulus for the double-ended queue, checked against
// a behavioral copy of the queue kept as a SystemVerilog queue of words.
module tb_top;
  import deq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Fields from bit 0: mode[2:0], position[13:3], word_in[45:14].
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Fields from bit 0: word_out[31:0], fill_count[42:32], is_empty[43],
  // status[45:44].
  logic [47:0] m_axis_tdata;

  localparam int unsigned WATCHDOG_LIMIT = 50000;

  // Contents of the queue as the testbench believes them, front at index 0.
  logic [WIDTH-1:0] queue_words[$];
  // Responses that the block still owes, oldest first.
  rsp_t             owed_rsp[$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  double_ended_queue_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Applies one request to the believed contents and returns the response
  // the block must give for it.
  function automatic rsp_t apply_request(op_t op, logic [10:0] pos,
                                         logic [WIDTH-1:0] word);
    rsp_t r;
    int unsigned n;
    n = queue_words.size();
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else queue_words.insert(n, word);
      end
      OP_PUSH_FRONT: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else queue_words.insert(0, word);
      end
      OP_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else queue_words.delete(n - 1);
      end
      OP_POP_FRONT: begin
        if (n == 0) r.status = ST_EMPTY;
        else queue_words.delete(0);
      end
      OP_READ: begin
        if (pos >= n) r.status = ST_RANGE;
        else r.word_out = queue_words[pos];
      end
      OP_INSERT: begin
        // The range test wins over the full test.
        if (pos > n) r.status = ST_RANGE;
        else if (n >= DEPTH) r.status = ST_FULL;
        else queue_words.insert(pos, word);
      end
      OP_ERASE: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (pos >= n) r.status = ST_RANGE;
        else queue_words.delete(pos);
      end
      default: begin
        queue_words.delete();
      end
    endcase
    r.fill_count = 11'(queue_words.size());
    r.is_empty   = (queue_words.size() == 0);
    return r;
  endfunction

  // Offers one request and waits until it is accepted. Valid stays high
  // between back-to-back requests; it is lowered only for an idle stretch.
  task automatic send_request(op_t op, logic [10:0] pos, logic [WIDTH-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, word, pos, op};
    do @(posedge clk); while (!s_axis_tready);
    owed_rsp.insert(owed_rsp.size(), apply_request(op, pos, word));
  endtask

  task automatic finish_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls at random at the selected rate.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compares every accepted response with the oldest owed one.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.word_out   = m_axis_tdata[31:0];
      got.fill_count = m_axis_tdata[42:32];
      got.is_empty   = m_axis_tdata[43];
      got.status     = status_t'(m_axis_tdata[45:44]);
      if (owed_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response %h", m_axis_tdata);
      end else begin
        want = owed_rsp[0];
        owed_rsp.delete(0);
        if (got.word_out !== want.word_out || got.fill_count !== want.fill_count ||
            got.is_empty !== want.is_empty || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: word %h/%h count %0d/%0d empty %b/%b status %0d/%0d",
                     want.word_out, got.word_out, want.fill_count, got.fill_count,
                     want.is_empty, got.is_empty, want.status, got.status);
        end
      end
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL double_ended_queue_top");
      $finish;
    end
  end

  // Every rejection on an empty queue, then basic end and middle operations.
  task automatic test_empty_and_basic();
    send_request(OP_POP_BACK, 11'd0, 32'h0);
    send_request(OP_POP_FRONT, 11'd0, 32'h0);
    send_request(OP_READ, 11'd0, 32'h0);
    send_request(OP_ERASE, 11'd0, 32'h0);
    send_request(OP_INSERT, 11'd1, 32'h1111_1111);
    send_request(OP_INSERT, 11'd2047, 32'h2222_2222);
    send_request(OP_INSERT, 11'd0, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 11'd2047, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 11'd0, 32'hA5A5_5A5A);
    send_request(OP_PUSH_BACK, 11'd0, 32'h1234_5678);
    send_request(OP_INSERT, 11'd4, 32'h8000_0001);  // append at the back
    send_request(OP_INSERT, 11'd1, 32'h0F0F_F0F0);  // shift the front side
    send_request(OP_INSERT, 11'd4, 32'hDEAD_BEEF);  // shift the back side
    send_request(OP_READ, 11'd0, 32'h0);
    send_request(OP_READ, 11'd6, 32'h0);
    send_request(OP_READ, 11'd7, 32'h0);
    send_request(OP_ERASE, 11'd1, 32'h0);
    send_request(OP_ERASE, 11'd4, 32'h0);
    send_request(OP_ERASE, 11'd5, 32'h0);
    send_request(OP_POP_BACK, 11'd0, 32'h0);
    send_request(OP_POP_FRONT, 11'd0, 32'h0);
    send_request(OP_CLEAR, 11'd0, 32'h0);
    send_request(OP_READ, 11'd0, 32'h0);
  endtask

  // Fills the queue to capacity from both ends and probes requests at and near capacity.
  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, 11'($urandom_range(2047)),
                   $urandom());
    send_request(OP_PUSH_BACK, 11'd0, 32'h1);
    send_request(OP_PUSH_FRONT, 11'd0, 32'h2);
    send_request(OP_INSERT, 11'd500, 32'h3);
    send_request(OP_INSERT, 11'd1024, 32'h4);
    send_request(OP_INSERT, 11'd1025, 32'h5);
    send_request(OP_READ, 11'd1023, 32'h0);
    send_request(OP_READ, 11'd1024, 32'h0);
    send_request(OP_ERASE, 11'd1, 32'h0);
    send_request(OP_INSERT, 11'd512, 32'h6);
    send_request(OP_ERASE, 11'd1020, 32'h0);
    send_request(OP_READ, 11'd511, 32'h0);
    send_request(OP_CLEAR, 11'd0, 32'h0);
  endtask

  // Random requests that keep the queue short so shifts stay cheap.
  task automatic test_random(int unsigned count);
    op_t         op;
    logic [10:0] pos;
    int unsigned n;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      n = queue_words.size();
      pick = $urandom_range(99);
      if (pick < 2) op = OP_CLEAR;
      else if (n > 40 && pick < 50) op = op_t'($urandom_range(2, 3));
      else if (n > 40) op = op_t'($urandom_range(4, 6));
      else op = op_t'($urandom_range(0, 6));
      pick = $urandom_range(99);
      if (pick < 80) pos = 11'($urandom_range(n));
      else if (pick < 90) pos = 11'(n + $urandom_range(3));
      else pos = 11'($urandom_range(2047));
      send_request(op, pos, $urandom());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_basic();
    test_full_queue();
    idle_pct = 0;  stall_pct = 0;  test_random(25);
    idle_pct = 50; stall_pct = 0;  test_random(25);
    idle_pct = 0;  stall_pct = 50; test_random(25);
    idle_pct = 16; stall_pct = 16; test_random(25);
    finish_sending();
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS double_ended_queue_top");
    end else begin
      $display("FAIL double_ended_queue_top");
    end
    $finish;
  end

endmodule
